@@ sv/pcp_pkg.sv @@
// Shared types, constants and helpers for the PCP response parser.
`default_nettype none
package pcp_pkg;

  localparam int CNT_BITS_DEF = 16;
  localparam int FIFO_DEPTH   = 4;
  localparam int TDATA_W      = 96;

  localparam logic [7:0] VER_RESET = 8'd2;
  localparam logic [7:0] RESP_BIT  = 8'h80;
  localparam int         HDR_BYTES = 24;
  localparam logic [6:0] MAP_BODY  = 7'h24;
  localparam logic [6:0] PEER_BODY = 7'h38;
  localparam int         OPT_HEAD  = 4;

  // result kinds
  localparam logic [1:0] KIND_FIELD    = 2'd0;
  localparam logic [1:0] KIND_OPT_HDR  = 2'd1;
  localparam logic [1:0] KIND_OPT_DATA = 2'd2;
  localparam logic [1:0] KIND_END      = 2'd3;

  // end status codes
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_TRUNC     = 3'd1;
  localparam logic [2:0] ST_BAD_VER   = 3'd2;
  localparam logic [2:0] ST_NOT_RESP  = 3'd3;
  localparam logic [2:0] ST_BAD_OP    = 3'd4;
  localparam logic [2:0] ST_MALF_OPT  = 3'd5;

  // opcode classes
  localparam logic [1:0] OP_ANNOUNCE = 2'd0;
  localparam logic [1:0] OP_MAP      = 2'd1;
  localparam logic [1:0] OP_PEER     = 2'd2;
  localparam logic [1:0] OP_UNKNOWN  = 2'd3;

  // field ids
  localparam logic [3:0] FID_OPCODE   = 4'd0;
  localparam logic [3:0] FID_RESULT   = 4'd1;
  localparam logic [3:0] FID_LIFETIME = 4'd2;
  localparam logic [3:0] FID_EPOCH    = 4'd3;
  localparam logic [3:0] FID_NONCE_HI = 4'd4;
  localparam logic [3:0] FID_NONCE_LO = 4'd5;
  localparam logic [3:0] FID_PROTO    = 4'd6;
  localparam logic [3:0] FID_INT_PORT = 4'd7;
  localparam logic [3:0] FID_EXT_PORT = 4'd8;
  localparam logic [3:0] FID_EXT_HI   = 4'd9;
  localparam logic [3:0] FID_EXT_LO   = 4'd10;
  localparam logic [3:0] FID_REM_PORT = 4'd11;
  localparam logic [3:0] FID_REM_HI   = 4'd12;
  localparam logic [3:0] FID_REM_LO   = 4'd13;

  typedef struct packed {
    logic [1:0]  kind;
    logic [3:0]  field_id;
    logic [63:0] field_value;
    logic [7:0]  option_code;
    logic [15:0] option_length;
    logic [2:0]  status;
    logic        end_of_message;
  } res_t;

  // up to two results produced by one beat, res0 first
  typedef struct packed {
    logic [1:0] num;
    res_t       res0;
    res_t       res1;
  } push_t;

  function automatic logic [6:0] body_len(input logic [1:0] op);
    case (op)
      OP_MAP:  body_len = MAP_BODY;
      OP_PEER: body_len = PEER_BODY;
      default: body_len = 7'd0;
    endcase
  endfunction

endpackage
`default_nettype wire

@@ sv/pcp_response_parser.sv @@
// PCP response parser, top level.
//
// Input stream: one message byte per beat on in_tdata, in_tlast on the final
// byte. Output stream: one result per beat; out_tuser carries the kind (field
// record, option header, option data byte, end status), out_tlast marks the
// end status record that closes each message. A non-ok status voids every
// record already sent for that message.
// Config: cfg_data sets the expected version byte (reset value 2); write only
// while the block is idle. cfg_ready is always high.
// Path: an accepted byte is held in the input register, its results are
// written into the queue once that holds room for two, and the queue head
// drives out_tdata.
// Throughput: one byte per cycle while the queue has room; a final byte
// that also completes a record yields two results, which drain at one per
// beat from a four-entry queue. The input register takes a byte while it
// is empty or the queue has room for two, so a stalled receiver backs up to
// in_tready, and no result is dropped.
// Reset (rst_n low, synchronous) clears message state and the queue and sets
// the version register back to 2.
`default_nettype none
module pcp_response_parser import pcp_pkg::*; #(
  parameter int COUNT_BITS = CNT_BITS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_tvalid,
  output logic                    in_tready,
  input  wire logic [7:0]         in_tdata,   // [7:0] data_byte
  input  wire logic               in_tlast,   // last_byte
  output logic                    out_tvalid,
  input  wire logic               out_tready,
  // [3:0] field_id, [67:4] field_value, [75:68] option_code,
  // [91:76] option_length, [94:92] status, [95] zero
  output logic [TDATA_W-1:0]      out_tdata,
  output logic [1:0]              out_tuser,  // [1:0] kind
  output logic                    out_tlast,  // end_of_message
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [7:0]         cfg_data    // expected_version
);

  logic       s_vld_r, s_vld_nxt;
  logic [7:0] s_byte_r;
  logic       s_last_r;
  logic [7:0] ver_r;
  logic       room2;
  logic       drain;
  logic       in_acc;
  push_t      push;
  res_t       head;

  assign cfg_ready = 1'b1;
  assign drain     = s_vld_r && room2;
  assign in_tready = !s_vld_r || room2;
  assign in_acc    = in_tvalid && in_tready;

  always_comb begin
    if (in_acc)     s_vld_nxt = 1'b1;
    else if (drain) s_vld_nxt = 1'b0;
    else            s_vld_nxt = s_vld_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_vld_r <= 1'b0;
      ver_r   <= VER_RESET;
    end else begin
      s_vld_r <= s_vld_nxt;
      if (cfg_valid) ver_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s_byte_r <= in_tdata;
      s_last_r <= in_tlast;
    end
  end

  pcp_parse #(.COUNT_BITS(COUNT_BITS)) u_parse (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (drain),
    .data_byte (s_byte_r),
    .last_byte (s_last_r),
    .exp_ver   (ver_r),
    .push      (push)
  );

  push_t push_g;
  always_comb begin
    push_g     = push;
    push_g.num = drain ? push.num : 2'd0;
  end

  pcp_out_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push_g),
    .pop      (out_tvalid && out_tready),
    .room2    (room2),
    .head_vld (out_tvalid),
    .head     (head)
  );

  assign out_tdata = {1'b0, head.status, head.option_length, head.option_code,
                      head.field_value, head.field_id};
  assign out_tuser = head.kind;
  assign out_tlast = head.end_of_message;

endmodule
`default_nettype wire

@@ sv/pcp_parse.sv @@
// Per-byte parse logic: message state and the results one byte produces.
`default_nettype none
module pcp_parse import pcp_pkg::*; #(
  parameter int COUNT_BITS = CNT_BITS_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       en,
  input  wire logic [7:0] data_byte,
  input  wire logic       last_byte,
  input  wire logic [7:0] exp_ver,
  output push_t           push
);

  localparam logic [COUNT_BITS-1:0] HDR   = COUNT_BITS'(HDR_BYTES);
  localparam logic [COUNT_BITS-1:0] HDR_M = COUNT_BITS'(HDR_BYTES - 1);

  logic [COUNT_BITS-1:0] cnt_r, cnt_nxt;
  logic [1:0]            op_r, op_nxt;
  logic [2:0]            he_r, he_nxt;
  logic [16:0]           pos_r, pos_nxt;
  logic [15:0]           olen_r, olen_nxt;
  logic [7:0]            ocode_r, ocode_nxt;
  logic [63:0]           acc_r, acc_nxt;

  logic [1:0]            op_n;
  logic [2:0]            he_n;
  logic [16:0]           pos_n;
  logic [15:0]           olen_n;
  logic [7:0]            ocode_n;
  logic [6:0]            plen;
  logic [5:0]            poff;
  logic [16:0]           pos1;
  logic [16:0]           opt_end;
  logic [2:0]            st;
  logic [6:0]            opc;
  res_t                  rec;
  logic                  rec_v;
  res_t                  end_rec;

  always_comb begin
    acc_nxt = {acc_r[55:0], data_byte};
    op_n    = op_r;
    he_n    = he_r;
    pos_n   = pos_r;
    olen_n  = olen_r;
    ocode_n = ocode_r;
    rec     = '0;
    rec_v   = 1'b0;
    plen    = body_len(op_r);
    poff    = 6'(cnt_r - HDR);
    pos1    = pos_r + 17'd1;
    opt_end = '0;
    opc     = data_byte[6:0];
    rec.kind = KIND_FIELD;

    if (cnt_r < HDR) begin
      case (cnt_r[4:0])
        5'd0: begin
          if (data_byte != exp_ver && he_r == ST_OK) he_n = ST_BAD_VER;
        end
        5'd1: begin
          if ((data_byte & RESP_BIT) == 8'd0 && he_n == ST_OK) he_n = ST_NOT_RESP;
          op_n = (opc <= 7'd2) ? opc[1:0] : OP_UNKNOWN;
          if (op_n == OP_UNKNOWN && he_n == ST_OK) he_n = ST_BAD_OP;
          rec_v = 1'b1;
          rec.field_id    = FID_OPCODE;
          rec.field_value = {57'd0, opc};
        end
        5'd3: begin
          rec_v = 1'b1;
          rec.field_id    = FID_RESULT;
          rec.field_value = {56'd0, data_byte};
        end
        5'd7: begin
          rec_v = 1'b1;
          rec.field_id    = FID_LIFETIME;
          rec.field_value = {32'd0, acc_nxt[31:0]};
        end
        5'd11: begin
          rec_v = 1'b1;
          rec.field_id    = FID_EPOCH;
          rec.field_value = {32'd0, acc_nxt[31:0]};
        end
        default: ;
      endcase
    end else if (he_r == ST_OK) begin
      if (cnt_r < HDR + COUNT_BITS'(plen)) begin
        rec_v = 1'b1;
        case (poff)
          6'd7:  begin rec.field_id = FID_NONCE_HI; rec.field_value = acc_nxt; end
          6'd11: begin
            rec.field_id = FID_NONCE_LO; rec.field_value = {32'd0, acc_nxt[31:0]};
          end
          6'd12: begin rec.field_id = FID_PROTO; rec.field_value = {56'd0, data_byte}; end
          6'd17: begin
            rec.field_id = FID_INT_PORT; rec.field_value = {48'd0, acc_nxt[15:0]};
          end
          6'd19: begin
            rec.field_id = FID_EXT_PORT; rec.field_value = {48'd0, acc_nxt[15:0]};
          end
          6'd27: begin rec.field_id = FID_EXT_HI; rec.field_value = acc_nxt; end
          6'd35: begin rec.field_id = FID_EXT_LO; rec.field_value = acc_nxt; end
          6'd37: begin
            rec.field_id = FID_REM_PORT; rec.field_value = {48'd0, acc_nxt[15:0]};
          end
          6'd47: begin rec.field_id = FID_REM_HI; rec.field_value = acc_nxt; end
          6'd55: begin rec.field_id = FID_REM_LO; rec.field_value = acc_nxt; end
          default: rec_v = 1'b0;
        endcase
      end else begin
        // option area: 4-byte header, content, padding to a multiple of four
        if (pos_r == 17'd0) begin
          ocode_n = data_byte;
        end else if (pos_r == 17'd2) begin
          olen_n = {8'd0, data_byte};
        end else if (pos_r == 17'd3) begin
          olen_n = {olen_r[7:0], data_byte};
          rec_v = 1'b1;
          rec.kind          = KIND_OPT_HDR;
          rec.option_code   = ocode_r;
          rec.option_length = olen_n;
        end else if (pos_r >= 17'(OPT_HEAD) && pos_r < 17'(OPT_HEAD) + {1'b0, olen_r}) begin
          rec_v = 1'b1;
          rec.kind          = KIND_OPT_DATA;
          rec.field_value   = {56'd0, data_byte};
          rec.option_code   = ocode_r;
          rec.option_length = olen_r;
        end
        opt_end = 17'(OPT_HEAD) + (({1'b0, olen_n} + 17'd3) & ~17'd3);
        if (pos_r >= 17'd3) pos_n = (pos1 >= opt_end) ? 17'd0 : pos1;
        else                pos_n = pos1;
      end
    end

    // status from the state as updated by this byte; size < N is count < N-1
    if (cnt_r < HDR_M)                                      st = ST_TRUNC;
    else if (he_n != ST_OK)                                 st = he_n;
    else if (cnt_r < HDR_M + COUNT_BITS'(body_len(op_n)))   st = ST_TRUNC;
    else if (pos_n != 17'd0)                                st = ST_MALF_OPT;
    else                                                    st = ST_OK;

    end_rec = '0;
    end_rec.kind           = KIND_END;
    end_rec.status         = st;
    end_rec.end_of_message = 1'b1;

    push.num  = {1'b0, rec_v} + {1'b0, last_byte};
    push.res0 = rec_v ? rec : end_rec;
    push.res1 = end_rec;

    if (last_byte) begin
      cnt_nxt   = '0;
      op_nxt    = OP_ANNOUNCE;
      he_nxt    = ST_OK;
      pos_nxt   = '0;
      olen_nxt  = '0;
      ocode_nxt = '0;
      acc_nxt   = '0;
    end else begin
      cnt_nxt   = (&cnt_r) ? cnt_r : cnt_r + 1'b1;
      op_nxt    = op_n;
      he_nxt    = he_n;
      pos_nxt   = pos_n;
      olen_nxt  = olen_n;
      ocode_nxt = ocode_n;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r   <= '0;
      op_r    <= OP_ANNOUNCE;
      he_r    <= ST_OK;
      pos_r   <= '0;
      olen_r  <= '0;
      ocode_r <= '0;
      acc_r   <= '0;
    end else if (en) begin
      cnt_r   <= cnt_nxt;
      op_r    <= op_nxt;
      he_r    <= he_nxt;
      pos_r   <= pos_nxt;
      olen_r  <= olen_nxt;
      ocode_r <= ocode_nxt;
      acc_r   <= acc_nxt;
    end
  end

endmodule
`default_nettype wire

@@ sv/pcp_out_fifo.sv @@
// Result queue: takes up to two results a cycle, hands out one per beat.
`default_nettype none
module pcp_out_fifo import pcp_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire push_t push,
  input  wire logic pop,
  output logic      room2,
  output logic      head_vld,
  output res_t      head
);

  localparam int PW = $clog2(FIFO_DEPTH);

  res_t          mem [FIFO_DEPTH];
  logic [PW-1:0] wr_r, rd_r;
  logic [PW:0]   cnt_r, cnt_nxt;
  logic [PW-1:0] wr_nxt, rd_nxt;

  assign room2    = cnt_r <= (PW+1)'(FIFO_DEPTH - 2);
  assign head_vld = cnt_r != '0;
  assign head     = mem[rd_r];

  always_comb begin
    cnt_nxt = cnt_r + (PW+1)'(push.num) - (PW+1)'(pop);
    wr_nxt  = wr_r + PW'(push.num);
    rd_nxt  = rd_r + PW'(pop);
  end

  always_ff @(posedge clk) begin
    if (push.num != 2'd0) mem[wr_r] <= push.res0;
    if (push.num == 2'd2) mem[wr_r + PW'(1)] <= push.res1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule
`default_nettype wire

@@ sv/pcp_checker.sv @@
// Port-level checks for the PCP response parser, bound to the top level.
`default_nettype none
module pcp_checker import pcp_pkg::*; (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               out_tvalid,
  input wire logic [TDATA_W-1:0] out_tdata,
  input wire logic [1:0]         out_tuser,
  input wire logic               out_tlast
);

  // end-of-message beat is exactly the status beat
  a_tlast_is_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tlast == (out_tuser == KIND_END)))
    else $error("tlast does not match end status kind");

  // status field is zero on every non-status beat
  a_status_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser != KIND_END) |-> (out_tdata[94:92] == ST_OK))
    else $error("status set on a non-status beat");

  // field records carry no option code or length
  a_field_no_opt: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser == KIND_FIELD) |-> (out_tdata[91:68] == 24'd0))
    else $error("option info on a field record");

  // queue is empty right after reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

  // status code stays within the defined set
  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser == KIND_END) |-> (out_tdata[94:92] <= ST_MALF_OPT))
    else $error("undefined status code");

endmodule

bind pcp_response_parser pcp_checker u_pcp_checker (.*);
`default_nettype wire

@@ dv/pcp_response_parser_checker.sv @@
// Checker for the PCP response parser: byte-level predictor and result scoreboard.
`timescale 1ns / 1ps
module pcp_response_parser_checker import pcp_pkg::*; #(
  parameter int COUNT_BITS = CNT_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  input  logic               in_tready,
  input  logic [7:0]         in_tdata,
  input  logic               in_tlast,
  input  logic               out_tvalid,
  input  logic               out_tready,
  input  logic [TDATA_W-1:0] out_tdata,
  input  logic [1:0]         out_tuser,
  input  logic               out_tlast,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic [7:0]         cfg_data,
  output int                 fails,
  output int                 pending,
  output int                 msgs_done,
  output int                 beats_checked,
  output logic [5:0]         codes_seen
);

  localparam longint unsigned COUNT_MAX = (64'd1 << COUNT_BITS) - 64'd1;

  res_t              records[$];   // results still owed by the block, oldest first
  logic [7:0]        want_ver;
  longint unsigned   msg_bytes;
  logic [1:0]        op_class;
  logic [2:0]        hdr_err;
  int unsigned       opt_pos;
  logic [15:0]       opt_len;
  logic [7:0]        opt_code;
  logic [63:0]       shift_reg;
  int                bad = 0;
  int                n_msgs = 0;
  int                n_beats = 0;
  logic [5:0]        codes;

  task automatic clear_msg();
    msg_bytes = 0;
    op_class  = OP_ANNOUNCE;
    hdr_err   = ST_OK;
    opt_pos   = 0;
    opt_len   = '0;
    opt_code  = '0;
    shift_reg = '0;
  endtask

  task automatic add_record(input logic [1:0] kind, input logic [3:0] id,
                            input logic [63:0] val, input logic [7:0] code,
                            input logic [15:0] len, input logic [2:0] st,
                            input logic eom);
    res_t r;
    r.kind           = kind;
    r.field_id       = id;
    r.field_value    = val;
    r.option_code    = code;
    r.option_length  = len;
    r.status         = st;
    r.end_of_message = eom;
    records.insert(records.size(), r);
  endtask

  task automatic add_field(input logic [3:0] id, input logic [63:0] val);
    add_record(KIND_FIELD, id, val, 8'd0, 16'd0, ST_OK, 1'b0);
  endtask

  // one message byte: update the parse state, queue whatever it completes
  task automatic decode_byte(input logic [7:0] d, input logic last);
    longint unsigned b;
    int unsigned     plen;
    int unsigned     pos;
    int unsigned     span;
    logic [2:0]      st;
    b = msg_bytes;
    shift_reg = {shift_reg[55:0], d};
    plen = (op_class == OP_MAP) ? MAP_BODY : (op_class == OP_PEER) ? PEER_BODY : 0;
    if (b < HDR_BYTES) begin
      case (b)
        0: if (d != want_ver && hdr_err == ST_OK) hdr_err = ST_BAD_VER;
        1: begin
          if (!d[7] && hdr_err == ST_OK) hdr_err = ST_NOT_RESP;
          op_class = (d[6:0] <= 7'd2) ? d[1:0] : OP_UNKNOWN;
          if (op_class == OP_UNKNOWN && hdr_err == ST_OK) hdr_err = ST_BAD_OP;
          add_field(FID_OPCODE, {57'd0, d[6:0]});
        end
        3:  add_field(FID_RESULT, {56'd0, d});
        7:  add_field(FID_LIFETIME, {32'd0, shift_reg[31:0]});
        11: add_field(FID_EPOCH, {32'd0, shift_reg[31:0]});
        default: ;
      endcase
    end else if (hdr_err == ST_OK) begin
      if (b < HDR_BYTES + plen) begin
        case (b - HDR_BYTES)
          7:  add_field(FID_NONCE_HI, shift_reg);
          11: add_field(FID_NONCE_LO, {32'd0, shift_reg[31:0]});
          12: add_field(FID_PROTO, {56'd0, d});
          17: add_field(FID_INT_PORT, {48'd0, shift_reg[15:0]});
          19: add_field(FID_EXT_PORT, {48'd0, shift_reg[15:0]});
          27: add_field(FID_EXT_HI, shift_reg);
          35: add_field(FID_EXT_LO, shift_reg);
          37: add_field(FID_REM_PORT, {48'd0, shift_reg[15:0]});
          47: add_field(FID_REM_HI, shift_reg);
          55: add_field(FID_REM_LO, shift_reg);
          default: ;
        endcase
      end else begin
        pos = opt_pos;
        if (pos == 0) begin
          opt_code = d;
        end else if (pos == 2) begin
          opt_len = {8'd0, d};
        end else if (pos == 3) begin
          opt_len = {opt_len[7:0], d};
          add_record(KIND_OPT_HDR, 4'd0, 64'd0, opt_code, opt_len, ST_OK, 1'b0);
        end else if (pos >= OPT_HEAD && pos < OPT_HEAD + 32'(opt_len)) begin
          add_record(KIND_OPT_DATA, 4'd0, {56'd0, d}, opt_code, opt_len, ST_OK, 1'b0);
        end
        // position runs through header, content and padding to a 4-byte boundary
        if (pos >= 3) begin
          span = OPT_HEAD + ((32'(opt_len) + 32'd3) & ~32'd3);
          opt_pos = (pos + 1 >= span) ? 0 : pos + 1;
        end else begin
          opt_pos = pos + 1;
        end
      end
    end

    if (b < COUNT_MAX) msg_bytes = b + 1;

    if (last) begin
      if (b + 1 < HDR_BYTES) st = ST_TRUNC;
      else if (hdr_err != ST_OK) st = hdr_err;
      else if (b + 1 < HDR_BYTES + plen) st = ST_TRUNC;
      else if (opt_pos != 0) st = ST_MALF_OPT;
      else st = ST_OK;
      add_record(KIND_END, 4'd0, 64'd0, 8'd0, 16'd0, st, 1'b1);
      clear_msg();
    end
  endtask

  task automatic check_item(input string name, input logic [63:0] want,
                            input logic [63:0] got);
    if (got !== want) begin
      bad++;
      $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    res_t w;
    if (!rst_n) begin
      records.delete();
      clear_msg();
      want_ver = VER_RESET;
      codes    = '0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (records.size() == 0) begin
          bad++;
          $display("%0t: result beat with nothing outstanding, expected none, got kind %0d data %h",
                   $time, out_tuser, out_tdata);
        end else begin
          w = records.pop_front();
          n_beats++;
          check_item("kind", 64'(w.kind), 64'(out_tuser));
          check_item("field_id", 64'(w.field_id), 64'(out_tdata[3:0]));
          check_item("field_value", w.field_value, out_tdata[67:4]);
          check_item("option_code", 64'(w.option_code), 64'(out_tdata[75:68]));
          check_item("option_length", 64'(w.option_length), 64'(out_tdata[91:76]));
          check_item("status", 64'(w.status), 64'(out_tdata[94:92]));
          check_item("tdata pad bit", 64'd0, 64'(out_tdata[95]));
          check_item("end_of_message", 64'(w.end_of_message), 64'(out_tlast));
          if (w.kind == KIND_END) begin
            n_msgs++;
            if (w.status <= ST_MALF_OPT) codes[w.status] = 1'b1;
          end
        end
      end
      if (cfg_valid && cfg_ready) want_ver = cfg_data;
      if (in_tvalid && in_tready) decode_byte(in_tdata, in_tlast);
    end
    fails         <= bad;
    pending       <= records.size();
    msgs_done     <= n_msgs;
    beats_checked <= n_beats;
    codes_seen    <= codes;
  end

endmodule

@@ dv/tb_pcp_response_parser.sv @@
// Testbench top for the PCP response parser: message stimulus, back-pressure and verdict.
`timescale 1ns / 1ps
module tb_pcp_response_parser;
  import pcp_pkg::*;

  typedef enum int {FILL_RAND, FILL_ZERO, FILL_ONES} fill_t;

  localparam int PHASE_BYTES = 10;
  localparam int SETTLE      = 8;
  localparam int HOLD_CYCLES = 300;

  logic               clk        = 1'b0;
  logic               rst_n      = 1'b0;
  logic               in_tvalid  = 1'b0;
  logic [7:0]         in_tdata   = 8'd0;
  logic               in_tlast   = 1'b0;
  logic               out_tready = 1'b0;
  logic               cfg_valid  = 1'b0;
  logic [7:0]         cfg_data   = 8'd0;
  logic               in_tready;
  logic               out_tvalid;
  logic [TDATA_W-1:0] out_tdata;
  logic [1:0]         out_tuser;
  logic               out_tlast;
  logic               cfg_ready;

  int                 fails;
  int                 pending;
  int                 msgs_done;
  int                 beats_checked;
  logic [5:0]         codes_seen;

  logic [7:0]         frame[$];
  fill_t              fill_mode  = FILL_RAND;
  int                 bytes_sent = 0;
  bit                 quiet      = 1'b0;
  bit                 squeezed   = 1'b0;

  pcp_response_parser uut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser), .out_tlast(out_tlast),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  pcp_response_parser_checker u_checker (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser), .out_tlast(out_tlast),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .fails(fails), .pending(pending), .msgs_done(msgs_done),
    .beats_checked(beats_checked), .codes_seen(codes_seen)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [7:0] filler();
    case (fill_mode)
      FILL_ZERO: return 8'h00;
      FILL_ONES: return 8'hFF;
      default:   return 8'($urandom);
    endcase
  endfunction

  task automatic add_byte(input logic [7:0] v);
    frame.insert(frame.size(), v);
  endtask

  task automatic add_bytes(input int n);
    repeat (n) add_byte(filler());
  endtask

  // version, opcode byte, then reserved, result code, lifetime, epoch, reserved
  task automatic add_header(input logic [7:0] ver, input logic [7:0] op_byte);
    add_byte(ver);
    add_byte(op_byte);
    add_bytes(HDR_BYTES - 2);
  endtask

  task automatic add_option(input logic [7:0] code, input logic [15:0] len);
    add_byte(code);
    add_byte(filler());
    add_byte(len[15:8]);
    add_byte(len[7:0]);
    add_bytes(((32'(len) + 3) & ~3) - 32'(len) + 32'(len));
  endtask

  task automatic send_frame();
    for (int i = 0; i < frame.size(); i++) begin
      if (!quiet && $urandom_range(0, 5) == 0) begin
        in_tvalid <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
      in_tvalid <= 1'b1;
      in_tdata  <= frame[i];
      in_tlast  <= (i == frame.size() - 1);
      do @(posedge clk); while (!in_tready);
      bytes_sent++;
    end
    frame.delete();
  endtask

  // drain everything owed, then let bytes that produce nothing settle
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_version(input logic [7:0] v);
    cfg_data  <= v;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // result side: random stalls, one long hold-off early on, always ready at the end
  initial begin
    while (!rst_n) @(posedge clk);
    forever begin
      if (quiet) begin
        out_tready <= 1'b1;
        @(posedge clk);
      end else if (!squeezed && bytes_sent >= 60) begin
        squeezed = 1'b1;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if ($urandom_range(0, 3) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end else begin
        out_tready <= 1'b1;
        repeat ($urandom_range(1, 24)) @(posedge clk);
      end
    end
  end

  initial begin
    #50_000_000;
    $display("watchdog expired with %0d results outstanding", pending);
    $display("FAIL");
    $finish;
  end

  initial begin
    logic [7:0] phase_ver [4];
    logic [7:0] op_byte;
    int         pick;
    int         keep;
    int         phase_bytes;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed messages at the reset version
    fill_mode = FILL_ONES;
    add_header(VER_RESET, RESP_BIT | 8'(OP_MAP));
    add_bytes(MAP_BODY);
    send_frame();

    fill_mode = FILL_ZERO;
    add_header(VER_RESET, RESP_BIT | 8'(OP_ANNOUNCE));
    add_option(8'h00, 16'd0);
    send_frame();

    fill_mode = FILL_RAND;
    add_header(VER_RESET, RESP_BIT | 8'(OP_PEER));
    add_bytes(PEER_BODY);
    add_option(8'hFF, 16'd1);
    add_option(8'($urandom), 16'd5);
    send_frame();

    // single-byte message
    add_byte(VER_RESET);
    send_frame();

    // header one byte short
    add_header(VER_RESET, RESP_BIT | 8'(OP_MAP));
    void'(frame.pop_back());
    send_frame();

    // full header, map payload missing entirely
    add_header(VER_RESET, RESP_BIT | 8'(OP_MAP));
    send_frame();

    // wrong version with a complete payload
    add_header(8'h03, RESP_BIT | 8'(OP_MAP));
    add_bytes(MAP_BODY);
    send_frame();

    // response bit clear
    add_header(VER_RESET, 8'(OP_PEER));
    send_frame();

    // unknown opcodes; trailing bytes ignored
    add_header(VER_RESET, RESP_BIT | 8'h03);
    add_bytes(9);
    send_frame();
    add_header(VER_RESET, 8'hFF);
    send_frame();

    // version and response bit both wrong: version wins
    add_header(8'h00, 8'h7F);
    send_frame();

    // map payload cut short
    add_header(VER_RESET, RESP_BIT | 8'(OP_MAP));
    add_bytes(20);
    send_frame();

    // option header cut after two bytes
    add_header(VER_RESET, RESP_BIT | 8'(OP_ANNOUNCE));
    add_byte(8'h01);
    add_byte(8'h00);
    send_frame();

    // option ends inside its padding
    add_header(VER_RESET, RESP_BIT | 8'(OP_ANNOUNCE));
    add_option(8'h12, 16'd6);
    void'(frame.pop_back());
    send_frame();

    phase_ver[0] = 8'hFF;
    phase_ver[1] = 8'h00;
    phase_ver[2] = 8'($urandom_range(3, 254));
    phase_ver[3] = VER_RESET;

    for (int ph = 0; ph < 4; ph++) begin
      wait_idle();
      write_version(phase_ver[ph]);
      quiet = (ph == 3);
      phase_bytes = 0;
      while (phase_bytes < PHASE_BYTES) begin
        fill_mode = FILL_RAND;
        pick = $urandom_range(0, 99);
        if (pick < 8) begin
          repeat ($urandom_range(1, 40)) add_byte(8'($urandom));
        end else begin
          op_byte = ($urandom_range(0, 6) == 0) ? 8'($urandom)
                                                : (RESP_BIT | 8'($urandom_range(0, 2)));
          add_header(($urandom_range(0, 9) == 0) ? 8'($urandom) : phase_ver[ph], op_byte);
          if (op_byte[6:0] == 7'(OP_MAP)) add_bytes(MAP_BODY);
          else if (op_byte[6:0] == 7'(OP_PEER)) add_bytes(PEER_BODY);
          else if (op_byte[6:0] != 7'(OP_ANNOUNCE)) add_bytes($urandom_range(0, 8));
          repeat ($urandom_range(0, 3))
            add_option(8'($urandom), ($urandom_range(0, 9) == 0) ? 16'($urandom_range(13, 40))
                                                                 : 16'($urandom_range(0, 12)));
          // broken message: stray option header with any length, cut anywhere
          if (pick < 30) begin
            repeat (4) add_byte(8'($urandom));
            keep = $urandom_range(1, frame.size());
            while (frame.size() > keep) void'(frame.pop_back());
          end
        end
        phase_bytes += frame.size();
        send_frame();
      end
    end

    wait_idle();
    $display("covered %0d bytes in %0d messages, %0d result beats compared",
             bytes_sent, msgs_done, beats_checked);
    $display("end codes reached (bit per code): %b; versions 0x02, 0xff, 0x00 and 0x%h",
             codes_seen, phase_ver[2]);
    if (fails == 0 && pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
